@@ rtl/core/stable_priority_queue_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue unit.
// Both macros wrap a concurrent assertion with a label and an error message.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Assertion that is switched off while reset is applied.
`define SPQ_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the stable priority queue controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned JobW   = 16;
  localparam int unsigned ValW   = 8;
  localparam int unsigned PriW   = 9;
  localparam int unsigned OccW   = 5;
  localparam int unsigned StatW  = 2;

  // Operation codes of an input item.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Status codes of a result item.
  localparam logic [StatW-1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [StatW-1:0] STAT_DEQUEUED = 2'd1;
  localparam logic [StatW-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [StatW-1:0] STAT_DROPPED  = 2'd3;

  typedef struct packed {
    logic            op;
    logic [JobW-1:0] job_in;
    logic [ValW-1:0] depth_in;
    logic [ValW-1:0] traffic_in;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [JobW-1:0]  job_out;
    logic [ValW-1:0]  depth_out;
    logic [ValW-1:0]  traffic_out;
    logic [PriW-1:0]  priority_out;
    logic [OccW-1:0]  occupancy;
    logic             now_empty;
  } out_item_t;

  // Contents of one storage slot.
  typedef struct packed {
    logic [JobW-1:0] job;
    logic [ValW-1:0] depth;
    logic [ValW-1:0] traffic;
    logic [PriW-1:0] prio;
  } slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             insert;
    logic             remove;
    logic             load;
    logic [StatW-1:0] status;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } spq_stat_t;

endpackage

@@ rtl/core/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: tracks whether a result is waiting in the output
// register and turns each accepted item into datapath commands.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  input  logic              out_stall_i,
  input  spq_pkg::spq_stat_t stat_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output spq_pkg::spq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // The output register only blocks new items while its result is stalled.
  assign in_stall_o  = (state_q == S_HOLD) && out_stall_i;
  assign out_valid_o = (state_q == S_HOLD);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!accept && !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.insert = accept && (in_op_i == spq_pkg::OP_ENQUEUE) && !stat_i.full;
    cmd_o.remove = accept && (in_op_i == spq_pkg::OP_DEQUEUE) && !stat_i.empty;
    if (in_op_i == spq_pkg::OP_ENQUEUE) begin
      cmd_o.status = stat_i.full ? spq_pkg::STAT_DROPPED : spq_pkg::STAT_ENQUEUED;
    end else begin
      cmd_o.status = stat_i.empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_DEQUEUED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/spq_dpath.sv @@
// ----------------------------------------------------------------------------
// spq_dpath
// Sorted slot array built as a row of cells, the job count and the output
// register. Every cell compares its priority with the new job in parallel.
// ----------------------------------------------------------------------------
module spq_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  spq_pkg::in_item_t   item_i,
  output spq_pkg::spq_stat_t  stat_o,
  output spq_pkg::out_item_t  item_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  spq_pkg::slot_t     slot_q [CAPACITY];
  spq_pkg::slot_t     slot_d [CAPACITY];
  spq_pkg::slot_t     new_slot;
  logic [CAPACITY-1:0] keep;
  logic [CntW-1:0]    count_q, count_d;
  spq_pkg::out_item_t out_q, out_d;

  always_comb begin
    new_slot.job     = item_i.job_in;
    new_slot.depth   = item_i.depth_in;
    new_slot.traffic = item_i.traffic_in;
    new_slot.prio    = spq_pkg::PriW'(item_i.depth_in) + spq_pkg::PriW'(item_i.traffic_in);
  end

  // A cell keeps its job on insert when it is occupied and its priority is
  // at least the new one. The list is sorted, so keep is a prefix.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign keep[i] = (CntW'(i) < count_q) && (slot_q[i].prio >= new_slot.prio);

    always_comb begin
      slot_d[i] = slot_q[i];
      if (cmd_i.insert) begin
        if (!keep[i]) begin
          if (i == 0) begin
            slot_d[i] = new_slot;
          end else if (keep[(i == 0) ? 0 : i - 1]) begin
            slot_d[i] = new_slot;
          end else begin
            slot_d[i] = slot_q[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (cmd_i.remove) begin
        slot_d[i] = slot_q[(i == CAPACITY - 1) ? i : i + 1];
      end
    end

    always_ff @(posedge clk_i) begin
      slot_q[i] <= slot_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_d.status       = cmd_i.status;
    out_d.job_out      = '0;
    out_d.depth_out    = '0;
    out_d.traffic_out  = '0;
    out_d.priority_out = '0;
    if (cmd_i.remove) begin
      out_d.job_out      = slot_q[0].job;
      out_d.depth_out    = slot_q[0].depth;
      out_d.traffic_out  = slot_q[0].traffic;
      out_d.priority_out = slot_q[0].prio;
    end
    out_d.occupancy = spq_pkg::OccW'(count_d);
    out_d.now_empty = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(CAPACITY));
  assign item_o       = out_q;

endmodule

@@ rtl/core/stable_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue of jobs kept sorted by depth plus traffic; equal
// priorities leave in arrival order.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o | spq_pkg::in_item_t
//   out     | output    | out_valid_o / out_stall_i | spq_pkg::out_item_t
//
// For each item, all cells compare against the new priority at once and
// shift in the same edge; the result is registered and appears in the next cycle.
// A new item is taken every cycle unless the waiting result is stalled.
// Reset empties the queue; slot contents are not cleared.
// A stalled result holds its value and blocks the input until taken.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_unit_assert.svh"

module stable_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spq_pkg::out_item_t out_item_o
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_item_i.op),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  spq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .item_i (in_item_i),
    .stat_o (stat),
    .item_o (out_item_o)
  );

  // A dropped enqueue changes nothing, so the queue is still full.
  `SPQ_ASSERT_RST(a_drop_full, clk_i, rst_ni,
    (out_valid_o && (out_item_o.status == spq_pkg::STAT_DROPPED)) |-> stat.full,
    "dropped enqueue reported while queue not full")

  // A dequeue on empty leaves the queue empty.
  `SPQ_ASSERT_RST(a_deq_empty, clk_i, rst_ni,
    (out_valid_o && (out_item_o.status == spq_pkg::STAT_EMPTY)) |-> stat.empty,
    "empty dequeue reported while queue holds jobs")

  // An enqueue that fits shows up as stored in the next result.
  `SPQ_ASSERT_RST(a_enq_stored, clk_i, rst_ni,
    (in_valid_i && !in_stall_o && (in_item_i.op == spq_pkg::OP_ENQUEUE) && !stat.full)
      |=> (out_valid_o && (out_item_o.status == spq_pkg::STAT_ENQUEUED) && !stat.empty),
    "accepted enqueue not reported as stored")

  // The queue can never be empty and full at once. The count may still be
  // unknown while reset is applied, so every edge in reset is let through.
  `SPQ_ASSERT_ALWAYS(a_empty_full, clk_i,
    !rst_ni || !(stat.empty && stat.full),
    "queue flagged empty and full together")

endmodule
